@@ hw/rtl/csvft_pkg.sv @@
`timescale 1ns / 1ps

package csvft_pkg;

  // byte codes
  localparam logic [7:0] QUOTE_BYTE = 8'h22;
  localparam logic [7:0] CR_BYTE    = 8'h0D;
  localparam logic [7:0] LF_BYTE    = 8'h0A;
  localparam logic [7:0] COMMA_BYTE = 8'h2C;

  // most tokens one byte can give rise to
  localparam int unsigned MAX_TOK = 3;
  localparam int unsigned TOK_CNT_W = 2;

  typedef enum logic [1:0] {
    KIND_CHAR  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [7:0] ch;
    kind_t      kind;
  } token_t;

  // all tokens caused by one accepted byte, oldest in slot 0
  typedef struct packed {
    logic [TOK_CNT_W-1:0] count;
    token_t [MAX_TOK-1:0] tok;
  } bundle_t;

  // line parsing state
  typedef struct packed {
    logic inside_quotes;
    logic quote_pending;
    logic cr_pending;
    logic after_closing_quote;
    logic field_is_empty;
    logic row_has_bytes;
  } line_st_t;

  localparam line_st_t LINE_RESET = '{
    inside_quotes:       1'b0,
    quote_pending:       1'b0,
    cr_pending:          1'b0,
    after_closing_quote: 1'b0,
    field_is_empty:      1'b1,
    row_has_bytes:       1'b0
  };

  typedef struct packed {
    line_st_t st;
    logic     v;
    token_t   tok;
  } plain_res_t;

  // handling of an ordinary byte (not a newline, nothing waiting)
  function automatic plain_res_t plain_byte(line_st_t st, logic [7:0] b, logic [7:0] delim);
    plain_res_t res;
    res.st = st;
    res.v = 1'b0;
    res.tok = '{ch: 8'h00, kind: KIND_CHAR};
    if (st.inside_quotes) begin
      if (b == QUOTE_BYTE) begin
        res.st.quote_pending = 1'b1;
      end else begin
        res.v = 1'b1;
        res.tok = '{ch: b, kind: KIND_CHAR};
        res.st.field_is_empty = 1'b0;
      end
    end else if (b == QUOTE_BYTE && st.field_is_empty && !st.after_closing_quote) begin
      res.st.inside_quotes = 1'b1;
    end else if (b == delim) begin
      res.v = 1'b1;
      res.tok = '{ch: 8'h00, kind: KIND_FIELD};
      res.st.field_is_empty = 1'b1;
      res.st.after_closing_quote = 1'b0;
    end else if (b != CR_BYTE) begin
      res.v = 1'b1;
      res.tok = '{ch: b, kind: KIND_CHAR};
      res.st.field_is_empty = 1'b0;
    end
    return res;
  endfunction

endpackage

@@ hw/rtl/csvft_front.sv @@
`timescale 1ns / 1ps

module csvft_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic [7:0]        in_byte,
  input  logic              in_end_of_data,
  input  logic              cfg_wr_en,
  input  logic [7:0]        cfg_wr_data,
  output logic              bundle_valid,
  output csvft_pkg::bundle_t bundle
);
  import csvft_pkg::*;

  logic [7:0] delim_r;
  line_st_t   st_r, st_nxt;

  plain_res_t pr_cr, pr_main;
  line_st_t   st;
  logic       va, vb, vc, used;
  token_t     ta, tb, tc;

  // delimiter register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= COMMA_BYTE;
    end else if (cfg_wr_en) begin
      delim_r <= cfg_wr_data;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= LINE_RESET;
    end else if (accept) begin
      st_r <= st_nxt;
    end
  end

  // classify the byte: waiting carriage return, waiting quote, the byte, end of data
  always_comb begin
    st = st_r;
    va = 1'b0;
    vb = 1'b0;
    vc = 1'b0;
    used = 1'b0;
    ta = '{ch: 8'h00, kind: KIND_CHAR};
    tb = '{ch: 8'h00, kind: KIND_CHAR};
    tc = '{ch: 8'h00, kind: KIND_ROW};
    pr_cr = plain_byte(st_r, CR_BYTE, delim_r);
    pr_main = '0;

    // carriage return held from the previous byte
    if (st.cr_pending) begin
      st.cr_pending = 1'b0;
      if (in_byte != LF_BYTE) begin
        pr_cr = plain_byte(st, CR_BYTE, delim_r);
        st = pr_cr.st;
        va = pr_cr.v;
        ta = pr_cr.tok;
      end
    end

    // quote held from the previous byte
    if (st.quote_pending) begin
      st.quote_pending = 1'b0;
      if (in_byte == QUOTE_BYTE) begin
        vb = 1'b1;
        tb = '{ch: QUOTE_BYTE, kind: KIND_CHAR};
        st.field_is_empty = 1'b0;
        st.row_has_bytes = 1'b1;
        used = 1'b1;
      end else begin
        st.inside_quotes = 1'b0;
        st.after_closing_quote = 1'b1;
      end
    end

    // the byte itself
    if (!used) begin
      if (in_byte == LF_BYTE) begin
        vb = 1'b1;
        tb = '{ch: 8'h00, kind: KIND_ROW};
        st = LINE_RESET;
      end else if (in_byte == CR_BYTE) begin
        st.cr_pending = 1'b1;
        st.row_has_bytes = 1'b1;
      end else begin
        st.row_has_bytes = 1'b1;
        pr_main = plain_byte(st, in_byte, delim_r);
        st = pr_main.st;
        vb = pr_main.v;
        tb = pr_main.tok;
      end
    end

    // end of data flushes the row
    if (in_end_of_data) begin
      vc = st.row_has_bytes;
      st = LINE_RESET;
    end

    st_nxt = st;
  end

  // pack the tokens into the bundle, oldest first
  always_comb begin
    bundle.count = TOK_CNT_W'({1'b0, va}) + TOK_CNT_W'({1'b0, vb}) + TOK_CNT_W'({1'b0, vc});
    bundle.tok[0] = tc;
    bundle.tok[1] = tc;
    bundle.tok[2] = tc;
    if (va) begin
      bundle.tok[0] = ta;
      bundle.tok[1] = vb ? tb : tc;
    end else if (vb) begin
      bundle.tok[0] = tb;
    end
  end

  assign bundle_valid = accept && (va || vb || vc);

endmodule

@@ hw/rtl/csvft_queue.sv @@
`timescale 1ns / 1ps

module csvft_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  csvft_pkg::bundle_t wr_data,
  output logic               full,
  input  logic               rd_en,
  output logic               empty,
  output csvft_pkg::bundle_t rd_data
);
  import csvft_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  bundle_t        slot_r [DEPTH];
  logic [PW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_wr, do_rd;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign rd_data = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/csvft_back.sv @@
`timescale 1ns / 1ps

module csvft_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               head_empty,
  input  csvft_pkg::bundle_t head,
  output logic               head_pop,
  output logic               empty,
  input  logic               pop,
  output logic [7:0]         out_char,
  output logic [1:0]         out_token_kind,
  output logic               out_run_last
);
  import csvft_pkg::*;

  logic [TOK_CNT_W-1:0] idx_r, idx_nxt;
  token_t               cur;
  logic                 last_tok;
  logic                 xfer;

  // pick the current token of the head bundle
  always_comb begin
    unique case (idx_r)
      2'd0:    cur = head.tok[0];
      2'd1:    cur = head.tok[1];
      2'd2:    cur = head.tok[2];
      default: cur = head.tok[0];
    endcase
  end

  assign last_tok = (idx_r == head.count - 1'b1);
  assign empty = head_empty;
  assign xfer = pop && !head_empty;
  assign head_pop = xfer && last_tok;

  assign out_char = cur.ch;
  assign out_token_kind = cur.kind;
  assign out_run_last = last_tok;

  // step through the bundle one token per transfer
  always_comb begin
    idx_nxt = idx_r;
    if (xfer) begin
      idx_nxt = last_tok ? '0 : idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
    end else begin
      idx_r <= idx_nxt;
    end
  end

endmodule

@@ hw/rtl/csv_field_tokenizer_top.sv @@
`timescale 1ns / 1ps

// CSV tokenizer with quoted fields. Bytes are pushed one per cycle and come out
// as field characters, end-of-field and end-of-row tokens; out_run_last marks the
// final token caused by a byte. A byte is classified in the cycle it is accepted
// and gives zero to three tokens, which are held together in a queue of
// QUEUE_DEPTH entries; the result side drains one token per cycle on pop, so the
// first token of a byte can be taken the cycle after its transfer. Bytes are taken
// every cycle as long as the queue has room; full rises only when QUEUE_DEPTH
// bytes' worth of tokens are waiting, so the sustained rate is one byte per cycle
// when the tokens it yields average at most one per byte, and otherwise is set by
// the one-token-per-cycle result side. cfg_wr_data sets the delimiter (comma
// after reset); the user writes it only while the block is idle, not enforced.

module csv_field_tokenizer_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_data,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_char,
  output logic [1:0] out_token_kind,
  output logic       out_run_last,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);
  import csvft_pkg::*;

  logic    accept;
  logic    bundle_valid;
  bundle_t bundle;
  bundle_t head;
  logic    head_empty;
  logic    head_pop;

  assign accept = push && !full;

  // front: classify bytes and track line state
  csvft_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .accept         (accept),
    .in_byte        (in_byte),
    .in_end_of_data (in_end_of_data),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .bundle_valid   (bundle_valid),
    .bundle         (bundle)
  );

  // queue of token bundles between the two sides
  csvft_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (bundle_valid),
    .wr_data (bundle),
    .full    (full),
    .rd_en   (head_pop),
    .empty   (head_empty),
    .rd_data (head)
  );

  // back: hand out tokens one per transfer
  csvft_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_empty     (head_empty),
    .head           (head),
    .head_pop       (head_pop),
    .empty          (empty),
    .pop            (pop),
    .out_char       (out_char),
    .out_token_kind (out_token_kind),
    .out_run_last   (out_run_last)
  );

endmodule
